// ----- sv/iazc_pkg.sv -----
`default_nettype none

package iazc_pkg;

    // command codes
    localparam logic [1:0] CMD_POLL      = 2'd0;
    localparam logic [1:0] CMD_SET_PERIM = 2'd1;
    localparam logic [1:0] CMD_SET_VOL   = 2'd2;

    // zone modes
    localparam logic [1:0] MODE_OFF_AUTO   = 2'd0;
    localparam logic [1:0] MODE_OFF_MANUAL = 2'd1;
    localparam logic [1:0] MODE_ON_AUTO    = 2'd2;
    localparam logic [1:0] MODE_ON_MANUAL  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_REMOTE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_DISARM_CODE    = 2'd1;
    localparam logic [1:0] REG_ARM_CODE       = 2'd2;

    // configuration reset values
    localparam logic [15:0] REMOTE_ADDRESS_RST = 16'h5956;
    localparam logic [7:0]  DISARM_CODE_RST    = 8'h99;
    localparam logic [7:0]  ARM_CODE_RST       = 8'hA9;
    localparam logic [7:0]  ALL_ONES           = 8'hFF;

    // acknowledge beeps
    localparam logic [1:0] BEEPS_NONE   = 2'd0;
    localparam logic [1:0] BEEPS_DISARM = 2'd1;
    localparam logic [1:0] BEEPS_ARM    = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  mode;
        logic [15:0] rx_address;
        logic [7:0]  rx_data;
        logic [7:0]  perimeter_sensors;
        logic [7:0]  volume_sensors;
    } iazc_in_t;

    typedef struct packed {
        logic [7:0] perimeter_level;
        logic [7:0] volume_level;
        logic       perimeter_armed;
        logic       volume_armed;
        logic       perimeter_tripped;
        logic       volume_tripped;
        logic       perimeter_alarm;
        logic       volume_alarm;
        logic       siren_stop;
        logic [1:0] beep_count;
        logic       clear_remote;
    } iazc_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic apply;
        logic sweep;
        logic finish;
    } iazc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_needed;
        logic sweep_last;
        logic out_free;
    } iazc_status_t;

    // off auto only from on auto; on auto refused while on manual
    function automatic logic mode_accepted(input logic [1:0] req, input logic [1:0] cur);
        logic ok;
        ok = 1'b1;
        if (req == MODE_OFF_AUTO && cur != MODE_ON_AUTO)
            ok = 1'b0;
        if (req == MODE_ON_AUTO && cur == MODE_ON_MANUAL)
            ok = 1'b0;
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- sv/iazc_ctrl.sv -----
`default_nettype none

module iazc_ctrl
    import iazc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire iazc_status_t status,
    output iazc_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_APPLY  = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // a request is taken only between items
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = status.sweep_needed ? ST_SWEEP : ST_FINISH;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_APPLY)
        else $error("accepted request did not move to apply");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && status.sweep_last) |=> state_reg == ST_FINISH)
        else $error("history sweep did not end on its last entry");

    a_finish_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !status.out_free) |=> state_reg == ST_FINISH)
        else $error("left finish while the result register was full");

endmodule

`default_nettype wire

// ----- sv/iazc_datapath.sv -----
`default_nettype none

module iazc_datapath
    import iazc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire iazc_in_t     in_item,
    input  wire iazc_cmd_t    cmd,
    output iazc_status_t      status,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output iazc_out_t         out_item
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    // configuration
    logic [15:0] remote_address_reg;
    logic [7:0]  disarm_code_reg;
    logic [7:0]  arm_code_reg;

    // captured request
    iazc_in_t    item_reg;

    // zone state
    logic [7:0]        hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]        p_mode_reg, p_mode_next;
    logic [1:0]        v_mode_reg, v_mode_next;
    logic              p_en_reg, p_en_next;
    logic              v_en_reg, v_en_next;
    logic              p_latch_reg, p_latch_next;
    logic              v_latch_reg, v_latch_next;
    logic [7:0]        p_status_reg, p_status_next;
    logic [7:0]        v_status_reg, v_status_next;

    // per item events and sweep
    logic              stop_reg, stop_next;
    logic [1:0]        beeps_reg, beeps_next;
    logic              clr_reg, clr_next;
    logic              swept_reg, swept_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [7:0]        acc_reg, acc_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    iazc_out_t         out_reg, out_next;

    logic remote_hit, disarm_hit, arm_hit, is_poll, sweep_needed, hist_we;
    logic p_alarm, v_alarm;

    assign is_poll    = (item_reg.command == CMD_POLL);
    assign remote_hit = is_poll && (item_reg.rx_address == remote_address_reg);
    assign disarm_hit = remote_hit && (item_reg.rx_data == disarm_code_reg);
    assign arm_hit    = remote_hit && !disarm_hit && (item_reg.rx_data == arm_code_reg);

    // remote press clears the latch before the sensor check
    assign sweep_needed = is_poll && !(disarm_hit || arm_hit) && !p_latch_reg
                          || is_poll && (disarm_hit || arm_hit);
    assign hist_we      = cmd.apply && sweep_needed;

    assign status.sweep_needed = sweep_needed;
    assign status.sweep_last   = (idx_reg == LAST_SLOT);
    assign status.out_free     = !out_valid_reg || !out_stall;

    // mode, remote, history sweep and result
    always_comb
    begin
        slot_next      = slot_reg;
        p_mode_next    = p_mode_reg;
        v_mode_next    = v_mode_reg;
        p_en_next      = p_en_reg;
        v_en_next      = v_en_reg;
        p_latch_next   = p_latch_reg;
        v_latch_next   = v_latch_reg;
        p_status_next  = p_status_reg;
        v_status_next  = v_status_reg;
        stop_next      = stop_reg;
        beeps_next     = beeps_reg;
        clr_next       = clr_reg;
        swept_next     = swept_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        p_alarm        = 1'b0;
        v_alarm        = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (cmd.apply)
        begin
            stop_next  = 1'b0;
            beeps_next = BEEPS_NONE;
            clr_next   = remote_hit;
            swept_next = sweep_needed;
            idx_next   = '0;
            acc_next   = ALL_ONES;
            case (item_reg.command)
                CMD_SET_PERIM:
                begin
                    if (mode_accepted(item_reg.mode, p_mode_reg))
                    begin
                        p_mode_next  = item_reg.mode;
                        p_en_next    = item_reg.mode[1];
                        p_latch_next = 1'b0;
                        stop_next    = 1'b1;
                    end
                end
                CMD_SET_VOL:
                begin
                    if (mode_accepted(item_reg.mode, v_mode_reg))
                    begin
                        v_mode_next  = item_reg.mode;
                        v_en_next    = item_reg.mode[1];
                        v_latch_next = 1'b0;
                        stop_next    = 1'b1;
                    end
                end
                CMD_POLL:
                begin
                    if (disarm_hit || arm_hit)
                    begin
                        p_mode_next  = disarm_hit ? MODE_OFF_MANUAL : MODE_ON_MANUAL;
                        v_mode_next  = disarm_hit ? MODE_OFF_MANUAL : MODE_ON_MANUAL;
                        p_en_next    = arm_hit;
                        v_en_next    = arm_hit;
                        p_latch_next = 1'b0;
                        v_latch_next = 1'b0;
                        stop_next    = 1'b1;
                        beeps_next   = disarm_hit ? BEEPS_DISARM : BEEPS_ARM;
                    end
                end
                default:
                begin
                end
            endcase
            if (hist_we)
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        end

        // one history entry per cycle into the running and
        if (cmd.sweep)
        begin
            acc_next = acc_reg & hist_reg[idx_reg];
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            if (swept_reg)
            begin
                p_status_next = acc_reg;
                if (p_en_reg && acc_reg != 8'd0)
                begin
                    p_latch_next = 1'b1;
                    p_alarm      = 1'b1;
                end
            end
            if (is_poll && !v_latch_reg)
            begin
                v_status_next = item_reg.volume_sensors;
                if (v_en_reg && item_reg.volume_sensors != 8'd0)
                begin
                    v_latch_next = 1'b1;
                    v_alarm      = 1'b1;
                end
            end
            out_valid_next             = 1'b1;
            out_next.perimeter_level   = p_status_next;
            out_next.volume_level      = v_status_next;
            out_next.perimeter_armed   = p_en_reg;
            out_next.volume_armed      = v_en_reg;
            out_next.perimeter_tripped = p_latch_next;
            out_next.volume_tripped    = v_latch_next;
            out_next.perimeter_alarm   = p_alarm;
            out_next.volume_alarm      = v_alarm;
            out_next.siren_stop        = stop_reg;
            out_next.beep_count        = beeps_reg;
            out_next.clear_remote      = clr_reg;
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_address_reg <= REMOTE_ADDRESS_RST;
            disarm_code_reg    <= DISARM_CODE_RST;
            arm_code_reg       <= ARM_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REMOTE_ADDRESS: remote_address_reg <= cfg_data;
                REG_DISARM_CODE:    disarm_code_reg    <= cfg_data[7:0];
                REG_ARM_CODE:       arm_code_reg       <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // request capture, result payload, sweep accumulator and index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        out_reg <= out_next;
        acc_reg <= acc_next;
        idx_reg <= idx_next;
    end

    // perimeter history, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= 8'd0;
        end
        else if (hist_we)
        begin
            hist_reg[slot_reg] <= item_reg.perimeter_sensors;
        end
    end

    // zone and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            p_mode_reg    <= MODE_OFF_AUTO;
            v_mode_reg    <= MODE_OFF_AUTO;
            p_en_reg      <= 1'b0;
            v_en_reg      <= 1'b0;
            p_latch_reg   <= 1'b0;
            v_latch_reg   <= 1'b0;
            p_status_reg  <= 8'd0;
            v_status_reg  <= 8'd0;
            stop_reg      <= 1'b0;
            beeps_reg     <= BEEPS_NONE;
            clr_reg       <= 1'b0;
            swept_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            p_mode_reg    <= p_mode_next;
            v_mode_reg    <= v_mode_next;
            p_en_reg      <= p_en_next;
            v_en_reg      <= v_en_next;
            p_latch_reg   <= p_latch_next;
            v_latch_reg   <= v_latch_next;
            p_status_reg  <= p_status_next;
            v_status_reg  <= v_status_next;
            stop_reg      <= stop_next;
            beeps_reg     <= beeps_next;
            clr_reg       <= clr_next;
            swept_reg     <= swept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_alarm_latches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.perimeter_alarm || out_item.volume_alarm)
        |-> (!out_item.perimeter_alarm || out_item.perimeter_tripped)
            && (!out_item.volume_alarm || out_item.volume_tripped))
        else $error("alarm reported without trip latch");

    a_beep_remote: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.beep_count != BEEPS_NONE
        |-> out_item.clear_remote && out_item.siren_stop)
        else $error("beeps without remote match and siren stop");

    a_disarm_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.beep_count == BEEPS_DISARM
        |-> !out_item.perimeter_armed && !out_item.volume_armed
            && !out_item.perimeter_tripped && !out_item.volume_tripped)
        else $error("disarm left a zone armed or tripped");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("history slot out of range");

endmodule

`default_nettype wire

// ----- sv/intrusion_alarm_zone_controller_core.sv -----
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------
// in       | in_valid / in_stall | in_item   (iazc_in_t)
// out      | out_valid/out_stall | out_item  (iazc_out_t)
// cfg      | cfg_we              | cfg_index, cfg_data
//
// a mode command, unused code or poll with the perimeter tripped and no remote press
// goes from acceptance through apply to finish, with the result registered at finish
// a poll that samples the perimeter adds the history sweep between apply and finish,
// which reads one register-file entry per cycle
// one request at a time; the next is taken while a result waits in the output register
// out_stall only holds the finished result, the next request still runs up to its end
// rst_n clears configuration to defaults, zones to off auto and the history to zero
`default_nettype none

module intrusion_alarm_zone_controller_core
    import iazc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire iazc_in_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output iazc_out_t        out_item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    iazc_cmd_t    cmd;
    iazc_status_t status;

    // sequencer
    iazc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // zone state, history and result register
    iazc_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ----- test/intrusion_alarm_zone_controller_core_tb.sv -----
`default_nettype none

module intrusion_alarm_zone_controller_core_tb
    import iazc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 10;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ZONE_PERIM = 0;
    localparam int ZONE_VOL = 1;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    iazc_in_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    iazc_out_t out_item;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_REMOTE_ADDRESS;
    logic [15:0] cfg_data = '0;

    // pacing of both sides, set per phase
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    iazc_in_t pending_requests[$];
    iazc_out_t expected_responses[$];
    int errors = 0;
    int responses_seen = 0;

    // shadow of the configuration registers
    logic [15:0] auth_address = REMOTE_ADDRESS_RST;
    logic [7:0] disarm_button = DISARM_CODE_RST;
    logic [7:0] arm_button = ARM_CODE_RST;

    // shadow of the zone state
    logic [7:0] perim_hist[HIST_DEPTH];
    int hist_slot = 0;
    logic [1:0] zone_mode[2];
    logic zone_en[2];
    logic zone_latch[2];
    logic [7:0] perim_status = '0;
    logic [7:0] vol_status = '0;

    intrusion_alarm_zone_controller_core #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
            perim_hist[i] = '0;
        for (int z = 0; z < 2; z++)
        begin
            zone_mode[z] = MODE_OFF_AUTO;
            zone_en[z] = 1'b0;
            zone_latch[z] = 1'b0;
        end
    end

    // mode request on one zone; returns 1 when the zone takes it
    function automatic logic apply_zone_mode(int zone, logic [1:0] req);
        if (req == MODE_OFF_AUTO && zone_mode[zone] != MODE_ON_AUTO)
            return 1'b0;
        if (req == MODE_ON_AUTO && zone_mode[zone] == MODE_ON_MANUAL)
            return 1'b0;
        zone_mode[zone] = req;
        zone_en[zone] = (req == MODE_ON_AUTO || req == MODE_ON_MANUAL);
        zone_latch[zone] = 1'b0;
        return 1'b1;
    endfunction

    // next zone response for one accepted request, advancing the shadow state
    function automatic iazc_out_t predict_zone_response(iazc_in_t req);
        iazc_out_t r;
        logic [7:0] acc;
        r = '0;
        case (req.command)
            CMD_SET_PERIM: r.siren_stop = apply_zone_mode(ZONE_PERIM, req.mode);
            CMD_SET_VOL: r.siren_stop = apply_zone_mode(ZONE_VOL, req.mode);
            CMD_POLL:
            begin
                // remote code first, then the sensors with the new enables
                if (req.rx_address == auth_address)
                begin
                    if (req.rx_data == disarm_button)
                    begin
                        r.siren_stop = 1'b1;
                        r.beep_count = BEEPS_DISARM;
                        void'(apply_zone_mode(ZONE_PERIM, MODE_OFF_MANUAL));
                        void'(apply_zone_mode(ZONE_VOL, MODE_OFF_MANUAL));
                    end
                    else if (req.rx_data == arm_button)
                    begin
                        r.siren_stop = 1'b1;
                        r.beep_count = BEEPS_ARM;
                        void'(apply_zone_mode(ZONE_PERIM, MODE_ON_MANUAL));
                        void'(apply_zone_mode(ZONE_VOL, MODE_ON_MANUAL));
                    end
                    r.clear_remote = 1'b1;
                end
                if (!zone_latch[ZONE_PERIM])
                begin
                    perim_hist[hist_slot] = req.perimeter_sensors;
                    hist_slot = (hist_slot + 1) % HIST_DEPTH;
                    acc = ALL_ONES;
                    for (int i = 0; i < HIST_DEPTH; i++)
                        acc = acc & perim_hist[i];
                    perim_status = acc;
                    if (zone_en[ZONE_PERIM] && acc != 8'h00)
                    begin
                        zone_latch[ZONE_PERIM] = 1'b1;
                        r.perimeter_alarm = 1'b1;
                    end
                end
                if (!zone_latch[ZONE_VOL])
                begin
                    vol_status = req.volume_sensors;
                    if (zone_en[ZONE_VOL] && vol_status != 8'h00)
                    begin
                        zone_latch[ZONE_VOL] = 1'b1;
                        r.volume_alarm = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.perimeter_level = perim_status;
        r.volume_level = vol_status;
        r.perimeter_armed = zone_en[ZONE_PERIM];
        r.volume_armed = zone_en[ZONE_VOL];
        r.perimeter_tripped = zone_latch[ZONE_PERIM];
        r.volume_tripped = zone_latch[ZONE_VOL];
        return r;
    endfunction

    function automatic iazc_in_t make_request(logic [1:0] cmd, logic [1:0] md,
        logic [15:0] addr, logic [7:0] data, logic [7:0] ps, logic [7:0] vs);
        iazc_in_t r;
        r.command = cmd;
        r.mode = md;
        r.rx_address = addr;
        r.rx_data = data;
        r.perimeter_sensors = ps;
        r.volume_sensors = vs;
        return r;
    endfunction

    // mostly polls with long runs of set perimeter bits, some remote presses
    function automatic iazc_in_t random_request();
        iazc_in_t r;
        int pick;
        r.command = CMD_POLL;
        r.mode = 2'($urandom_range(0, 3));
        r.rx_address = 16'($urandom_range(0, 65535));
        r.rx_data = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.perimeter_sensors = ALL_ONES;
        else if (pick < 80)
            r.perimeter_sensors = 8'($urandom_range(0, 255));
        else if (pick < 90)
            r.perimeter_sensors = 8'h00;
        else
            r.perimeter_sensors = 8'h01 << $urandom_range(0, 7);
        r.volume_sensors = ($urandom_range(0, 99) < 60) ? 8'h00 : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.command = CMD_UNUSED;
        else if (pick < 20)
            r.command = CMD_SET_PERIM;
        else if (pick < 37)
            r.command = CMD_SET_VOL;
        else if ($urandom_range(0, 99) < 25)
        begin
            r.rx_address = auth_address;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.rx_data = disarm_button;
            else if (pick < 60)
                r.rx_data = arm_button;
        end
        return r;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR: response %0d: %s", responses_seen, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            flag_error($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_responses.push_back(predict_zone_response(in_item));
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_requests.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // response monitor
    always @(posedge clk)
    begin
        iazc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            responses_seen++;
            if (expected_responses.size() == 0)
                flag_error("response with nothing outstanding");
            else
            begin
                want = expected_responses.pop_front();
                compare_field("perimeter_level", want.perimeter_level, out_item.perimeter_level);
                compare_field("volume_level", want.volume_level, out_item.volume_level);
                compare_field("perimeter_armed", 8'(want.perimeter_armed),
                    8'(out_item.perimeter_armed));
                compare_field("volume_armed", 8'(want.volume_armed),
                    8'(out_item.volume_armed));
                compare_field("perimeter_tripped", 8'(want.perimeter_tripped),
                    8'(out_item.perimeter_tripped));
                compare_field("volume_tripped", 8'(want.volume_tripped),
                    8'(out_item.volume_tripped));
                compare_field("perimeter_alarm", 8'(want.perimeter_alarm),
                    8'(out_item.perimeter_alarm));
                compare_field("volume_alarm", 8'(want.volume_alarm),
                    8'(out_item.volume_alarm));
                compare_field("siren_stop", 8'(want.siren_stop), 8'(out_item.siren_stop));
                compare_field("beep_count", 8'(want.beep_count), 8'(out_item.beep_count));
                compare_field("clear_remote", 8'(want.clear_remote),
                    8'(out_item.clear_remote));
            end
        end
    end

    // wait until every request is through and every response checked
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0)
            @(negedge clk);
        repeat (HIST_DEPTH + 4) @(negedge clk);
    endtask

    task automatic write_setting(logic [1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_REMOTE_ADDRESS: auth_address = value;
            REG_DISARM_CODE: disarm_button = value[7:0];
            REG_ARM_CODE: arm_button = value[7:0];
            default: ;
        endcase
    endtask

    task automatic queue_random(int n);
        iazc_in_t r;
        int counted;
        counted = 0;
        while (counted < n)
        begin
            r = random_request();
            pending_requests.push_back(r);
            if (r.command != CMD_UNUSED)
                counted++;
        end
    endtask

    task automatic run_phase(logic [15:0] addr, logic [7:0] dis, logic [7:0] arm,
        int idle, int stall, int n);
        wait_drained();
        write_setting(REG_REMOTE_ADDRESS, addr);
        write_setting(REG_DISARM_CODE, {8'h00, dis});
        write_setting(REG_ARM_CODE, {8'h00, arm});
        @(negedge clk);
        send_idle_pct = idle;
        stall_pct = stall;
        queue_random(n);
    endtask

    // stimulus
    initial
    begin
        logic [7:0] shared_code;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: mode acceptance, remote codes, trip and latch behaviour
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, 16'h0000, 8'h00,
            ALL_ONES, 8'h00));
        pending_requests.push_back(make_request(CMD_UNUSED, MODE_ON_MANUAL, 16'hFFFF, 8'hFF,
            ALL_ONES, ALL_ONES));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_OFF_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_ON_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_OFF_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_ON_MANUAL, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_ON_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_OFF_MANUAL, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_VOL, MODE_ON_MANUAL, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_VOL, MODE_ON_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_SET_VOL, MODE_OFF_AUTO, 16'h0, 8'h0,
            8'h0, 8'h0));
        // matching address with another code, volume trips
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, REMOTE_ADDRESS_RST,
            8'h00, ALL_ONES, 8'h80));
        // tripped volume ignores its sample
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, 16'h0000, 8'h00,
            ALL_ONES, 8'h01));
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, REMOTE_ADDRESS_RST,
            DISARM_CODE_RST, ALL_ONES, 8'h00));
        // arm press then trip on the same poll
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, REMOTE_ADDRESS_RST,
            ARM_CODE_RST, ALL_ONES, ALL_ONES));
        // fill the perimeter history until the AND is nonzero
        repeat (5)
            pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, 16'hFFFF, 8'hFF,
                ALL_ONES, 8'h00));
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, 16'h0000, 8'h00,
            8'h00, 8'h00));
        pending_requests.push_back(make_request(CMD_SET_PERIM, MODE_OFF_MANUAL, 16'h0, 8'h0,
            8'h0, 8'h0));
        pending_requests.push_back(make_request(CMD_POLL, MODE_OFF_AUTO, 16'h0000, 8'h00,
            8'h00, 8'h00));
        queue_random(300);

        // register extremes and a range of pacing
        run_phase(16'h0000, 8'h00, 8'hFF, 79, 0, 300);
        run_phase(16'hFFFF, 8'hFF, 8'h00, 0, 79, 300);
        shared_code = 8'($urandom_range(0, 255));
        run_phase(16'($urandom_range(0, 65535)), shared_code, shared_code, 20, 20, 300);

        // long receiver hold-off while requests keep coming
        run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 0, 0, 300);
        hold_requests++;

        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- intrusion_alarm_zone_controller_core.f -----
sv/iazc_pkg.sv
sv/iazc_ctrl.sv
sv/iazc_datapath.sv
sv/intrusion_alarm_zone_controller_core.sv
test/intrusion_alarm_zone_controller_core_tb.sv
